@@ rtl/bnia_pkg.sv @@
package bnia_pkg;

  // newton iteration count and fixed-point constants
  localparam int          NEWTON_STEPS = 6;
  localparam int          STEP_W       = $clog2(NEWTON_STEPS);
  localparam logic [31:0] Y_INIT       = 32'h3000_0000;
  localparam logic [31:0] Y_ONE        = 32'h4000_0000;
  localparam logic [33:0] THREE_Q30    = 34'h0_C000_0000;

  // configuration register indexes
  localparam logic [1:0] CFG_EPSILON       = 2'd0;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd1;
  localparam logic [1:0] CFG_PLANE_SIZE    = 2'd2;

  // item and result codes
  localparam logic       OPC_LOAD    = 1'b0;
  localparam logic       OPC_SAMPLE  = 1'b1;
  localparam logic       KIND_LOAD   = 1'b0;
  localparam logic       KIND_SAMPLE = 1'b1;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SAT      = 2'd1;
  localparam logic [1:0] ST_ZERO     = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_NORM, S_YY, S_MY2, S_D, S_YD, S_UPDY, S_MAG, S_GAIN, S_ZGAIN,
    S_OFFMUL, S_OFFQ, S_OFFSAT, S_LDONE, S_SMUL, S_SACC, S_SABS, S_SDONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD_IN, OP_SAMPLE_IN, OP_NORM, OP_YY, OP_MY2, OP_D, OP_YD,
    OP_UPDY, OP_MAG, OP_GAIN, OP_ZGAIN, OP_OFFMUL, OP_OFFQ, OP_OFFSAT,
    OP_LOAD_OUT, OP_SMUL, OP_SACC, OP_SABS, OP_SAMPLE_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic s_zero;
    logic norm_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/bnia_in_if.sv @@
interface bnia_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [7:0]         load_channel;
  logic signed [15:0] gamma;
  logic signed [15:0] beta;
  logic signed [15:0] mean;
  logic [15:0]        variance;
  logic signed [15:0] sample;

  modport source (output valid, opcode, load_channel, gamma, beta, mean, variance, sample,
                  input ready);
  modport sink (input valid, opcode, load_channel, gamma, beta, mean, variance, sample,
                output ready);
endinterface

@@ rtl/bnia_out_if.sv @@
interface bnia_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] value;
  logic [7:0]         channel;
  logic [1:0]         status;

  modport source (output valid, kind, value, channel, status, input ready);
  modport sink (input valid, kind, value, channel, status, output ready);
endinterface

@@ rtl/bnia_cfg_if.sv @@
interface bnia_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [20:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/batchnorm_inference_affine.sv @@
// Fused batch normalization for inference, Q8.8 data with Q16.16 coefficients.
// req carries one item per transfer: opcode 0 loads gamma, beta, mean and
// variance for load_channel; opcode 1 carries one sample of an NCHW stream.
// rsp returns exactly one result per item: a load acknowledgment (kind 0,
// status 2 when variance plus epsilon is zero) or a normalized sample.
// cfg writes epsilon (0), channel_count (1) and plane_size (2); it is always
// ready and should be used only while the block is idle.
// One item is in work at a time. A sample passes through table read,
// multiply, add, magnitude and round. A load runs a normalizing shift of
// two bits per cycle, six Newton steps on the shared 32x32 multiplier,
// then gain and offset. A zero root load skips the Newton steps.
// The result sits in an output register; when rsp stalls, the block still
// accepts the next item and holds its result until the register frees.
// Reset (rst, synchronous) sets epsilon, channel_count and plane_size to 1 and
// clears the stream position; the channel tables are not cleared and every
// channel must be loaded before its samples arrive.
module batchnorm_inference_affine import bnia_pkg::*; #(
  parameter int MAX_CHANNELS = 256
) (
  input  logic       clk,
  input  logic       rst,
  bnia_in_if.sink    req,
  bnia_out_if.source rsp,
  bnia_cfg_if.sink   cfg
);

  dp_cmd_t    cmd;
  dp_status_t stat;

  assign cfg.ready = 1'b1;

  // sequencer
  bnia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_opcode(req.opcode),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic, tables and result register
  bnia_dpath #(.MAX_CHANNELS(MAX_CHANNELS)) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_load_channel(req.load_channel),
    .in_gamma       (req.gamma),
    .in_beta        (req.beta),
    .in_mean        (req.mean),
    .in_variance    (req.variance),
    .in_sample      (req.sample),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_kind       (rsp.kind),
    .out_value      (rsp.value),
    .out_channel    (rsp.channel),
    .out_status     (rsp.status)
  );

endmodule

@@ rtl/bnia_ram.sv @@
module bnia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bnia_ctrl.sv @@
module bnia_ctrl import bnia_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_opcode,
  output logic       in_ready,
  input  dp_status_t stat,
  output dp_cmd_t    cmd
);

  state_t              state, state_next;
  logic [STEP_W-1:0]   step, step_next;

  // state and newton step registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        step_next = '0;
        if (in_valid) begin
          if (in_opcode == OPC_SAMPLE) begin
            cmd.op     = OP_SAMPLE_IN;
            state_next = S_SMUL;
          end else begin
            cmd.op     = OP_LOAD_IN;
            state_next = S_NORM;
          end
        end
      end
      S_NORM: begin
        if (stat.s_zero) begin
          state_next = S_ZGAIN;
        end else if (stat.norm_done) begin
          state_next = S_YY;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      S_YY: begin
        cmd.op     = OP_YY;
        state_next = S_MY2;
      end
      S_MY2: begin
        cmd.op     = OP_MY2;
        state_next = S_D;
      end
      S_D: begin
        cmd.op     = OP_D;
        state_next = S_YD;
      end
      S_YD: begin
        cmd.op     = OP_YD;
        state_next = S_UPDY;
      end
      S_UPDY: begin
        cmd.op = OP_UPDY;
        if (step == STEP_W'(NEWTON_STEPS - 1)) begin
          state_next = S_MAG;
        end else begin
          step_next  = step + 1'b1;
          state_next = S_YY;
        end
      end
      S_MAG: begin
        cmd.op     = OP_MAG;
        state_next = S_GAIN;
      end
      S_GAIN: begin
        cmd.op     = OP_GAIN;
        state_next = S_OFFMUL;
      end
      S_ZGAIN: begin
        cmd.op     = OP_ZGAIN;
        state_next = S_OFFMUL;
      end
      S_OFFMUL: begin
        cmd.op     = OP_OFFMUL;
        state_next = S_OFFQ;
      end
      S_OFFQ: begin
        cmd.op     = OP_OFFQ;
        state_next = S_OFFSAT;
      end
      S_OFFSAT: begin
        cmd.op     = OP_OFFSAT;
        state_next = S_LDONE;
      end
      S_LDONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_LOAD_OUT;
          state_next = S_IDLE;
        end
      end
      S_SMUL: begin
        cmd.op     = OP_SMUL;
        state_next = S_SACC;
      end
      S_SACC: begin
        cmd.op     = OP_SACC;
        state_next = S_SABS;
      end
      S_SABS: begin
        cmd.op     = OP_SABS;
        state_next = S_SDONE;
      end
      S_SDONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_SAMPLE_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // accepted transfer always starts work
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("accepted item did not start work");

  // gain magnitude only after the last newton step
  a_mag_after_newton: assert property (@(posedge clk) disable iff (rst)
    state == S_MAG |-> $past(state) == S_UPDY && $past(step) == STEP_W'(NEWTON_STEPS - 1))
    else $error("gain computed before newton finished");

  // zero root never enters the newton loop
  a_zero_skips_newton: assert property (@(posedge clk) disable iff (rst)
    state == S_NORM && stat.s_zero |=> state == S_ZGAIN)
    else $error("zero variance entered newton loop");

endmodule

@@ rtl/bnia_dpath.sv @@
module bnia_dpath import bnia_pkg::*; #(
  parameter int MAX_CHANNELS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         stat,
  input  logic [7:0]         in_load_channel,
  input  logic signed [15:0] in_gamma,
  input  logic signed [15:0] in_beta,
  input  logic signed [15:0] in_mean,
  input  logic [15:0]        in_variance,
  input  logic signed [15:0] in_sample,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [20:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic signed [15:0] out_value,
  output logic [7:0]         out_channel,
  output logic [1:0]         out_status
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // configuration and stream counters
  logic [15:0] epsilon;
  logic [8:0]  channel_count;
  logic [20:0] plane_size;
  logic [7:0]  cur_ch, cur_ch_next;
  logic [19:0] pos, pos_next;
  logic [8:0]  lim_c, ch_inc;
  logic [20:0] lim_p, pos_inc;

  // working registers
  logic [7:0]         ch_r;
  logic               ch_ok;
  logic signed [15:0] g_r, b_r, mu_r, x_r;
  logic [16:0]        s_r;
  logic [31:0]        m, y, d;
  logic [4:0]         sh;
  logic [63:0]        uprod;
  logic signed [47:0] sprod;
  logic signed [31:0] gain, off;
  logic signed [39:0] q_r;
  logic signed [48:0] acc;
  logic [48:0]        amag;
  logic               aneg;
  logic [1:0]         status_r;

  // combinational helpers
  logic [33:0]  t;
  logic [15:0]  gmag;
  logic [5:0]   shamt;
  logic [63:0]  mag64;
  logic [31:0]  mag32;
  logic [47:0]  qtmp;
  logic [41:0]  diff;
  logic [32:0]  rq;
  logic [31:0]  gain_rd, off_rd, gsel, osel;
  logic         ram_we, ram_re;

  assign lim_c = (channel_count == 9'd0) ? 9'd1 :
                 (channel_count > 9'd256) ? 9'd256 : channel_count;
  assign lim_p = (plane_size == 21'd0) ? 21'd1 :
                 (plane_size > 21'd1048576) ? 21'd1048576 : plane_size;

  // next stream position
  always_comb begin
    pos_inc     = {1'b0, pos} + 21'd1;
    ch_inc      = {1'b0, cur_ch} + 9'd1;
    pos_next    = pos_inc[19:0];
    cur_ch_next = cur_ch;
    if (pos_inc[19:0] == 20'd0 || pos_inc >= lim_p) begin
      pos_next = '0;
      if (ch_inc[7:0] == 8'd0 || ch_inc >= lim_c) begin
        cur_ch_next = '0;
      end else begin
        cur_ch_next = ch_inc[7:0];
      end
    end
  end

  // configuration registers and stream counters
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon       <= 16'd1;
      channel_count <= 9'd1;
      plane_size    <= 21'd1;
      cur_ch        <= '0;
      pos           <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_EPSILON) begin
        epsilon <= cfg_data[15:0];
      end
      if (cfg_we && cfg_index == CFG_CHANNEL_COUNT) begin
        channel_count <= cfg_data[8:0];
      end
      if (cfg_we && cfg_index == CFG_PLANE_SIZE) begin
        plane_size <= cfg_data;
      end
      if (cfg_we && (cfg_index == CFG_CHANNEL_COUNT || cfg_index == CFG_PLANE_SIZE)) begin
        cur_ch <= '0;
        pos    <= '0;
      end else if (cmd.op == OP_SAMPLE_IN) begin
        cur_ch <= cur_ch_next;
        pos    <= pos_next;
      end
    end
  end

  // per-step arithmetic helpers
  always_comb begin
    t     = uprod[63:30];
    gmag  = g_r[15] ? 16'(-g_r) : 16'(g_r);
    shamt = 6'd33 - {2'b00, sh[4:1]};
    mag64 = uprod >> shamt;
    mag32 = mag64[31:0];
    qtmp  = sprod + (sprod[47] ? 48'sd255 : 48'sd0);
    diff  = {{18{b_r[15]}}, b_r, 8'b0} - {{2{q_r[39]}}, q_r};
    rq    = 33'((amag + 49'd32768) >> 16);
    gsel  = ch_ok ? gain_rd : '0;
    osel  = ch_ok ? off_rd : '0;
  end

  // parameter tables
  assign ram_we = (cmd.op == OP_LOAD_OUT) && ch_ok;
  assign ram_re = (cmd.op == OP_SAMPLE_IN);

  bnia_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_gain_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(ch_r)),
    .wdata(gain),
    .re   (ram_re),
    .raddr(AW'(cur_ch)),
    .rdata(gain_rd)
  );

  bnia_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_off_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(ch_r)),
    .wdata(off),
    .re   (ram_re),
    .raddr(AW'(cur_ch)),
    .rdata(off_rd)
  );

  // datapath operations
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD_IN: begin
        ch_r     <= in_load_channel;
        ch_ok    <= 32'(in_load_channel) < MAX_CHANNELS;
        g_r      <= in_gamma;
        b_r      <= in_beta;
        mu_r     <= in_mean;
        s_r      <= {1'b0, in_variance} + {1'b0, epsilon};
        m        <= {15'b0, {1'b0, in_variance} + {1'b0, epsilon}};
        sh       <= '0;
        y        <= Y_INIT;
        status_r <= ST_OK;
      end
      OP_SAMPLE_IN: begin
        ch_r  <= cur_ch;
        ch_ok <= 32'(cur_ch) < MAX_CHANNELS;
        x_r   <= in_sample;
      end
      OP_NORM: begin
        if (m[31:30] == 2'b00) begin
          m  <= m << 2;
          sh <= sh + 5'd2;
        end
      end
      OP_YY:   uprod <= 64'(y) * 64'(y);
      OP_MY2:  uprod <= 64'(m) * 64'(uprod[61:30]);
      OP_D:    d <= (t >= THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - t);
      OP_YD:   uprod <= 64'(y) * 64'(d);
      OP_UPDY: y <= uprod[62:31];
      OP_MAG:  uprod <= 64'(gmag) * 64'(y);
      OP_GAIN: gain <= g_r[15] ? (~mag32 + 32'd1) : mag32;
      OP_ZGAIN: begin
        gain     <= g_r[15] ? 32'h8000_0000 :
                    (g_r == 16'sd0) ? 32'h0 : 32'h7FFF_FFFF;
        status_r <= ST_ZERO;
      end
      OP_OFFMUL: sprod <= 48'($signed(mu_r)) * 48'($signed(gain));
      OP_OFFQ:   q_r <= qtmp[47:8];
      OP_OFFSAT: begin
        if (diff[41:31] == '0 || diff[41:31] == '1) begin
          off <= diff[31:0];
        end else begin
          off <= diff[41] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          if (status_r == ST_OK) begin
            status_r <= ST_SAT;
          end
        end
      end
      OP_LOAD_OUT: begin
        out_kind    <= KIND_LOAD;
        out_value   <= '0;
        out_channel <= ch_r;
        out_status  <= status_r;
      end
      OP_SMUL: begin
        sprod <= 48'($signed(gsel)) * 48'($signed(x_r));
        off   <= osel;
      end
      OP_SACC: acc <= 49'(sprod) + 49'($signed({off, 8'b0}));
      OP_SABS: begin
        amag <= acc[48] ? (~acc + 49'd1) : acc;
        aneg <= acc[48];
      end
      OP_SAMPLE_OUT: begin
        out_kind    <= KIND_SAMPLE;
        out_channel <= ch_r;
        if (!aneg && rq > 33'd32767) begin
          out_value  <= 16'sh7FFF;
          out_status <= ST_SAT;
        end else if (aneg && rq > 33'd32768) begin
          out_value  <= -16'sh8000;
          out_status <= ST_SAT;
        end else begin
          out_value  <= aneg ? 16'(-rq) : rq[15:0];
          out_status <= ST_OK;
        end
      end
      default: ;
    endcase
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_LOAD_OUT || cmd.op == OP_SAMPLE_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.s_zero    = (s_r == 17'd0);
  assign stat.norm_done = (m[31:30] != 2'b00);
  assign stat.out_free  = !out_valid || out_ready;

  // newton estimate stays at or below one
  a_y_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_UPDY |=> y <= Y_ONE)
    else $error("reciprocal root estimate above one");

  // normalized mantissa and even shift before gain scaling
  a_norm_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_MAG |-> !sh[0] && sh <= 5'd30 && m[31:30] != 2'b00)
    else $error("bad normalization before gain");

  // result register fills only from a finishing operation
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == OP_LOAD_OUT || cmd.op == OP_SAMPLE_OUT))
    else $error("result appeared without a finishing operation");

endmodule
